@@ rtl/core/dss_pkg.sv @@
// dss_pkg: shared types and constants for the delimiter string splitter.
// Holds the payload structs, the cell control struct and register indexes.
// No dependencies.
`default_nettype none

package dss_pkg;

  // Configuration register indexes
  localparam logic CFG_SEP_LEN   = 1'b0;
  localparam logic CFG_SEP_BYTES = 1'b1;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SEP_LEN_W = 4;
  localparam int unsigned SEP_W     = 64;

  // One input item: a string byte and its end flag
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  // One result: either a part byte or a part end
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              part_end;
    logic              done_res;
  } out_item_t;

  // Per-cycle control for the window cells
  typedef struct packed {
    logic load;  // take the incoming string byte
    logic pop;   // take the right neighbor's byte (window shifts toward oldest)
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/delimiter_string_splitter.sv @@
// Splits a byte string at leftmost non-overlapping occurrences of a separator.
// Input channel (in_valid/in_stall/in_data): one string byte per transfer,
//   in_last set on the final byte. Output channel (out_valid/out_stall/
//   out_data): one result per transfer, either a part byte (byte_valid) or a
//   part end (part_end), done_res on the last result of a string.
// Config port: cfg_we/cfg_index/cfg_data; index 0 = sep_len, 1 = sep_bytes.
//   Write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. A byte's result, if
//   any, is registered in the output buffer. A final byte that completes no
//   separator yields one result per cycle while the buffer has room, for each
//   held byte plus the part end; in_stall stays high until all are buffered.
// The separator compare is a row of SEP_MAX byte cells, each checking its own
//   slot in parallel; popping a byte shifts the row one cell toward the head.
// Reset: window empty, sep_len = 1, sep_bytes = 0, output buffer empty.
// Receiver stall: a two-entry output buffer absorbs results; once it is full,
//   in_stall rises and the window holds its contents.
`default_nettype none

module delimiter_string_splitter
  import dss_pkg::*;
#(
  parameter int unsigned SEP_MAX = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [SEP_W-1:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(SEP_MAX + 1);

  // Configuration registers
  logic [SEP_LEN_W-1:0] sep_len_r;
  logic [SEP_W-1:0]     sep_bytes_r;

  // Step control
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             act_r, act_nxt;
  logic             last_r, last_nxt;

  logic [SEP_LEN_W-1:0] len_clip;
  logic [CNT_W-1:0]     sep_l;
  logic                 full;
  logic                 go;
  logic                 accept;
  logic [CNT_W-1:0]     view_cnt;
  logic                 view_last;
  logic                 pop_en;
  logic                 push;
  out_item_t            push_data;
  logic                 match;

  logic [BYTE_W-1:0] view_byte [SEP_MAX];
  logic [SEP_MAX-1:0] eq_vec;
  logic [SEP_MAX-1:0] used_vec;

  // Effective separator length: 0 acts as 1, above SEP_MAX acts as SEP_MAX
  always_comb begin
    if (sep_len_r == '0)
      len_clip = SEP_LEN_W'(1);
    else if (sep_len_r > SEP_LEN_W'(SEP_MAX))
      len_clip = SEP_LEN_W'(SEP_MAX);
    else
      len_clip = sep_len_r;
  end
  assign sep_l = len_clip[CNT_W-1:0];

  // Handshake: busy popping surplus or flushing, or output buffer full
  assign in_stall = act_r || full;
  assign go       = !full && (act_r || in_valid);
  assign accept   = go && !act_r;

  assign view_cnt  = accept ? (count_r + CNT_W'(1)) : count_r;
  assign view_last = accept ? in_data.in_last : last_r;

  // Window cells
  genvar gi;
  generate
    for (gi = 0; gi < SEP_MAX; gi++) begin : g_cell
      cell_ctl_t         ctl;
      logic [BYTE_W-1:0] right;

      assign ctl.load = accept && (count_r == CNT_W'(gi));
      assign ctl.pop  = pop_en;
      assign used_vec[gi] = (CNT_W'(gi) < sep_l);

      if (gi == SEP_MAX - 1) begin : g_tail
        assign right = '0;
      end else begin : g_mid
        assign right = view_byte[gi+1];
      end

      dss_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_byte   (in_data.in_byte),
        .right_byte (right),
        .sep_byte   (sep_bytes_r[BYTE_W*gi +: BYTE_W]),
        .view_byte  (view_byte[gi]),
        .eq         (eq_vec[gi])
      );
    end
  endgenerate

  assign match = &(eq_vec | ~used_vec);

  // One action per cycle: pop surplus, compare a full window, flush, or just take the byte
  always_comb begin
    pop_en    = 1'b0;
    push      = 1'b0;
    push_data = '0;
    count_nxt = count_r;
    act_nxt   = act_r;
    last_nxt  = last_r;
    if (go) begin
      last_nxt = view_last;
      priority if (view_cnt > sep_l) begin
        pop_en               = 1'b1;
        push                 = 1'b1;
        push_data.out_byte   = view_byte[0];
        push_data.byte_valid = 1'b1;
        count_nxt            = view_cnt - CNT_W'(1);
        act_nxt              = 1'b1;
      end else if (view_cnt == sep_l) begin
        push = 1'b1;
        if (match) begin
          push_data.part_end = 1'b1;
          push_data.done_res = view_last;
          count_nxt          = '0;
          act_nxt            = 1'b0;
        end else begin
          pop_en               = 1'b1;
          push_data.out_byte   = view_byte[0];
          push_data.byte_valid = 1'b1;
          count_nxt            = view_cnt - CNT_W'(1);
          act_nxt              = view_last;
        end
      end else if (view_last && (view_cnt != '0)) begin
        pop_en               = 1'b1;
        push                 = 1'b1;
        push_data.out_byte   = view_byte[0];
        push_data.byte_valid = 1'b1;
        count_nxt            = view_cnt - CNT_W'(1);
        act_nxt              = 1'b1;
      end else if (view_last) begin
        push               = 1'b1;
        push_data.part_end = 1'b1;
        push_data.done_res = 1'b1;
        count_nxt          = '0;
        act_nxt            = 1'b0;
      end else begin
        count_nxt = view_cnt;
        act_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      act_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      act_r   <= act_nxt;
      last_r  <= last_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_len_r   <= SEP_LEN_W'(1);
      sep_bytes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEP_LEN:   sep_len_r   <= cfg_data[SEP_LEN_W-1:0];
        CFG_SEP_BYTES: sep_bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output buffer
  dss_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/dss_cell.sv @@
// dss_cell: one byte slot of the pending window.
// Depends on dss_pkg for cell_ctl_t and BYTE_W.
`default_nettype none

module dss_cell
  import dss_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [BYTE_W-1:0] new_byte,
  input  wire logic [BYTE_W-1:0] right_byte,
  input  wire logic [BYTE_W-1:0] sep_byte,
  output logic      [BYTE_W-1:0] view_byte,
  output logic                   eq
);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  // Slot content as seen this cycle, with an incoming byte bypassed in
  assign view_byte = ctl.load ? new_byte : byte_r;
  assign eq        = (view_byte == sep_byte);
  assign byte_nxt  = ctl.pop ? right_byte : view_byte;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/dss_skid.sv @@
// dss_skid: two-entry result buffer between the splitter engine and the output.
// Depends on dss_pkg for out_item_t.
`default_nettype none

module dss_skid
  import dss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_data,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  out_item_t   ent0_r, ent0_nxt;
  out_item_t   ent1_r, ent1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent0_r;
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;

  // Entry 0 is the head; entry 1 moves up on a transfer
  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_nxt  = cnt_r;
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) ent0_nxt = push_data;
        else               ent1_nxt = push_data;
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        ent0_nxt = ent1_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          ent0_nxt = push_data;
        end else begin
          ent0_nxt = ent1_r;
          ent1_nxt = push_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

endmodule

`default_nettype wire

@@ sim/tb_delimiter_string_splitter.sv @@
// Self-checking testbench for delimiter_string_splitter.
// Needs dss_pkg and the splitter RTL. It predicts the split results itself,
// drives random idle and stall gaps on both channels, and checks every result.
`timescale 1ns / 1ps

module tb_delimiter_string_splitter;
  import dss_pkg::*;

  localparam int unsigned SEP_MAX     = 8;
  localparam int unsigned DRAIN_WAIT  = SEP_MAX + 6;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = CFG_SEP_LEN;
  logic [SEP_W-1:0] cfg_data  = '0;

  delimiter_string_splitter #(
    .SEP_MAX(SEP_MAX)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Splitter prediction state: separator registers and held-back window
  logic [3:0]       sep_len_q = 4'd1;
  logic [SEP_W-1:0] sep_q     = '0;
  logic [7:0]       win [SEP_MAX];
  int unsigned      win_cnt   = 0;
  out_item_t        parts_due [$];

  // Run bookkeeping
  int unsigned errors       = 0;
  int unsigned cycles       = 0;
  int unsigned held_cycles  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned results_seen = 0;
  int unsigned sep_settings = 0;

  // Idle control shared between the tests and the receiver process
  bit          sender_gaps  = 1'b1;
  bit          recv_stalls  = 1'b1;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned run_left     = 0;

  logic [7:0]  text_q [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective separator length: 0 acts as 1, above SEP_MAX acts as SEP_MAX
  function automatic int unsigned eff_sep_len();
    if (sep_len_q == 4'd0) return 1;
    if (sep_len_q > SEP_MAX) return SEP_MAX;
    return 32'(sep_len_q);
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic bv, input logic pe,
                                      input logic dn);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = bv;
    r.part_end   = pe;
    r.done_res   = dn;
    parts_due.push_back(r);
  endfunction

  function automatic logic [7:0] shift_out_oldest();
    logic [7:0] b;
    b = win[0];
    for (int i = 0; i < SEP_MAX - 1; i++) win[i] = win[i + 1];
    win[SEP_MAX - 1] = 8'h00;
    if (win_cnt > 0) win_cnt--;
    return b;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < SEP_MAX; i++) win[i] = 8'h00;
    win_cnt = 0;
  endfunction

  // Expected results for one accepted string byte
  function automatic void predict_split(input logic [7:0] b, input logic last);
    int unsigned l;
    logic        hit;
    l   = eff_sep_len();
    hit = 1'b0;
    if (win_cnt > SEP_MAX - 1) win_cnt = SEP_MAX - 1;
    win[win_cnt] = b;
    win_cnt++;
    // surplus after a shorter separator was set mid-string
    while (win_cnt > l) push_result(shift_out_oldest(), 1'b1, 1'b0, 1'b0);
    if (win_cnt == l) begin
      hit = 1'b1;
      for (int i = 0; i < l; i++) if (win[i] != sep_q[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        clear_window();
        push_result(8'h00, 1'b0, 1'b1, last);
      end else begin
        push_result(shift_out_oldest(), 1'b1, 1'b0, 1'b0);
      end
    end
    // final byte without a match: flush held bytes, then close the part
    if (last) begin
      if (!hit) begin
        while (win_cnt > 0) push_result(shift_out_oldest(), 1'b1, 1'b0, 1'b0);
        push_result(8'h00, 1'b0, 1'b1, 1'b1);
      end
      clear_window();
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!sender_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  // Offer one string byte and wait for its transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    in_item_t    item;
    gap          = pick_gap();
    item.in_byte = b;
    item.in_last = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_split(b, last);
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Hold the input idle until every expected result is back, then let the
  // block finish any work that produces no result
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (parts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [SEP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_SEP_LEN) sep_len_q = value[3:0];
    else sep_q = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_separator(input logic [3:0] len, input logic [SEP_W-1:0] pattern);
    write_reg(CFG_SEP_LEN, {{(SEP_W-4){1'b0}}, len});
    write_reg(CFG_SEP_BYTES, pattern);
    sep_settings++;
  endtask

  // Random separator: mostly short, some long, a few out-of-range lengths
  task automatic pick_separator();
    logic [3:0]       len;
    logic [SEP_W-1:0] pattern;
    int unsigned      r;
    r = $urandom_range(0, 19);
    if (r < 12) len = 4'($urandom_range(1, 4));
    else if (r < 16) len = 4'($urandom_range(5, 8));
    else if (r < 18) len = 4'd0;
    else len = 4'($urandom_range(9, 15));
    case ($urandom_range(0, 2))
      0: pattern = {$urandom, $urandom};
      1: begin
        for (int i = 0; i < SEP_MAX; i++)
          pattern[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
      end
      default: pattern = {SEP_MAX{8'($urandom)}};
    endcase
    set_separator(len, pattern);
  endtask

  // Random string built from separators, separator prefixes and loose bytes
  task automatic build_text();
    int unsigned target;
    int unsigned l;
    int unsigned n;
    l      = eff_sep_len();
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
    text_q.delete();
    while (text_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: for (int i = 0; i < l; i++) text_q.push_back(sep_q[8*i +: 8]);
        3, 4: begin
          n = (l > 1) ? $urandom_range(1, l - 1) : 1;
          for (int i = 0; i < n; i++) text_q.push_back(sep_q[8*i +: 8]);
        end
        5, 6, 7: text_q.push_back(sep_q[8*$urandom_range(0, l - 1) +: 8]);
        default: text_q.push_back(8'($urandom));
      endcase
    end
  endtask

  // Receiver: random stall runs, or a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!recv_stalls) begin
      out_stall <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      run_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b1;
      run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end
  end

  // Compare each result transfer with the oldest expected one
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (parts_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: byte=%02h bv=%0b pe=%0b dn=%0b", out_data.out_byte,
                   out_data.byte_valid, out_data.part_end, out_data.done_res);
      end else begin
        want = parts_due.pop_front();
        if (want.out_byte !== out_data.out_byte || want.byte_valid !== out_data.byte_valid ||
            want.part_end !== out_data.part_end || want.done_res !== out_data.done_res) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch (byte/bv/pe/dn): expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                     want.out_byte, want.byte_valid, want.part_end, want.done_res,
                     out_data.out_byte, out_data.byte_valid, out_data.part_end,
                     out_data.done_res);
        end
      end
    end
  end

  // Watchdog and input hold-off count
  always @(posedge clk) begin
    cycles++;
    if (in_valid && in_stall) held_cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Reset separator (one zero byte): leading and trailing separator, plain byte
  task automatic test_reset_separator();
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_drain();
  endtask

  // Three-byte separator with a false start before the real match
  task automatic test_multibyte_separator();
    set_separator(4'd3, 64'h0000_0000_0063_6261);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(8'h78, 1'b1);
    wait_drain();
  endtask

  // Length 0 acts as 1; length above the maximum acts as the maximum
  task automatic test_sep_len_limits();
    set_separator(4'd0, {SEP_W{1'b1}});
    send_byte(8'hFF, 1'b1);
    wait_drain();
    set_separator(4'd15, 64'h0807_0605_0403_0201);
    for (int i = 1; i <= SEP_MAX; i++) send_byte(8'(i), i == SEP_MAX);
    wait_drain();
  endtask

  // Shorten the separator while bytes are held back
  task automatic test_len_change_mid_string();
    set_separator(4'd8, {SEP_MAX{8'hA5}});
    repeat (5) send_byte(8'h5A, 1'b0);
    wait_drain();
    set_separator(4'd2, 64'h0000_0000_0000_5A5A);
    send_byte(8'h5A, 1'b1);
    wait_drain();
  endtask

  // Well-formed strings with random content and random idle patterns
  task automatic test_random_strings(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_drain();
        pick_separator();
      end
      sender_gaps = ($urandom_range(0, 4) != 0);
      recv_stalls = ($urandom_range(0, 4) != 0);
      build_text();
      send_text();
    end
    sender_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering: the block fills up
  task automatic test_backpressure();
    int unsigned start;
    wait_drain();
    sender_gaps  = 1'b0;
    recv_stalls  = 1'b0;
    hold_request = 120;
    start        = bytes_sent;
    while (bytes_sent - start < 40) begin
      build_text();
      send_text();
    end
    wait_drain();
    sender_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  // Arbitrary bytes and end flags, with separator changes inside strings
  task automatic test_noise(input int unsigned n_bytes);
    for (int i = 0; i < n_bytes; i++) begin
      if (i % 12 == 0) begin
        wait_drain();
        pick_separator();
      end
      send_byte(8'($urandom), $urandom_range(0, 5) == 0);
    end
    send_byte(8'($urandom), 1'b1);
  endtask

  initial begin
    clear_window();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_separator();
    test_multibyte_separator();
    test_sep_len_limits();
    test_len_change_mid_string();
    test_random_strings(170);
    test_backpressure();
    test_noise(40);
    wait_drain();

    if (parts_due.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", parts_due.size());
    end
    $display("split %0d strings (%0d bytes) into %0d results over %0d separator settings",
             strings_sent, bytes_sent, results_seen, sep_settings);
    $display("input held off for %0d cycles; %0d mismatches", held_cycles, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
